>>> rtl/lagbest_pkg.sv
// lagbest_pkg: shared types, widths and codes for the best-lag squared-difference search.
// No dependencies; imported by every module of the block.

package lagbest_pkg;

  // sample and score widths
  localparam int SAMPLE_W = 16;
  localparam int FIELD_CH = 4;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SQ_W     = 32;
  localparam int SCORE_W  = 34;
  localparam int LAG_OUT_W = 7;
  localparam int RAND_W   = 16;

  // default parameter values
  localparam int DEFAULT_CHANNELS = 4;
  localparam int DEFAULT_MAX_LAGS = 64;

  // result queue
  localparam int FIFO_DEPTH = 8;

  // configuration port
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_MINIMIZE = 2'd0;

  // item kinds
  localparam logic KIND_CENTER = 1'b0;
  localparam logic KIND_CAND   = 1'b1;

  // input item
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] value_0;
    logic signed [SAMPLE_W-1:0] value_1;
    logic signed [SAMPLE_W-1:0] value_2;
    logic signed [SAMPLE_W-1:0] value_3;
    logic                       last;
    logic [RAND_W-1:0]          rand_fraction;
  } sample_t;

  // result item
  typedef struct packed {
    logic [LAG_OUT_W-1:0] best_lag;
    logic [SCORE_W-1:0]   best_score;
    logic [LAG_OUT_W-1:0] tie_count;
    logic                 overflow;
  } result_t;

  // control carried alongside the lane stage
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              last;
    logic [RAND_W-1:0] rand_fraction;
  } stage_ctl_t;

endpackage

>>> rtl/lagbest_lane.sv
// lagbest_lane: one channel lane, difference against the center and its square.
// Depends on lagbest_pkg for widths.

module lagbest_lane import lagbest_pkg::*; (
  input  logic                       clk,
  input  logic signed [SAMPLE_W-1:0] center,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic [SQ_W-1:0]            sq
);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;

  // signed difference, one bit wider than the samples
  assign diff = $signed({center[SAMPLE_W-1], center}) - $signed({sample[SAMPLE_W-1], sample});
  assign prod = diff * diff;

  // squared difference always fits in 32 bits
  always_ff @(posedge clk) begin
    sq <= prod[SQ_W-1:0];
  end

endmodule

>>> rtl/lagbest_merge.sv
// lagbest_merge: sums the lane squares, keeps the running best and its tie list,
// and picks the reported tie on the last candidate. Depends on lagbest_pkg.

module lagbest_merge import lagbest_pkg::*; #(
  parameter int LANES    = DEFAULT_CHANNELS,
  parameter int MAX_LAGS = DEFAULT_MAX_LAGS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             minimize,
  input  stage_ctl_t       s1_ctl,
  input  logic [SQ_W-1:0]  lane_sq [LANES],
  output logic             res_valid,
  output result_t          res_item
);

  localparam int CNT_W  = $clog2(MAX_LAGS + 1);
  localparam int IDX_W  = $clog2(MAX_LAGS);
  localparam int PROD_W = RAND_W + CNT_W;

  // sum stage
  stage_ctl_t         sum_ctl;
  logic [SCORE_W-1:0] sum_score;
  logic [SCORE_W-1:0] sum_comb;

  // search state
  logic [SCORE_W-1:0] best_so_far, best_so_far_next;
  logic [CNT_W-1:0]   ties_held, ties_held_next;
  logic [CNT_W-1:0]   lags_seen, lags_seen_next;
  logic               overflow_seen, overflow_seen_next;

  // values after this candidate, before any clear
  logic [SCORE_W-1:0] upd_best;
  logic [CNT_W-1:0]   upd_ties;
  logic [CNT_W-1:0]   upd_lags;
  logic               upd_ovf;
  logic               emit;
  logic [CNT_W-1:0]   lag_new;
  logic               better;

  // tie list memory
  logic [CNT_W-1:0] tie_mem [MAX_LAGS];
  logic             tie_we;
  logic [IDX_W-1:0] tie_waddr;

  // pick stage
  logic               pick_valid;
  logic [SCORE_W-1:0] pick_best;
  logic [CNT_W-1:0]   pick_ties;
  logic               pick_ovf;
  logic [RAND_W-1:0]  pick_rand;
  logic [PROD_W-1:0]  pick_prod;
  logic [IDX_W-1:0]   pick_idx;

  // read stage
  logic [CNT_W-1:0]   rd_lag;
  logic [SCORE_W-1:0] rd_best;
  logic [CNT_W-1:0]   rd_ties;
  logic               rd_ovf;

  // adder over the lanes
  always_comb begin
    sum_comb = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_comb = sum_comb + SCORE_W'(lane_sq[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ctl.valid <= 1'b0;
    end else begin
      sum_ctl.valid <= s1_ctl.valid;
    end
    sum_ctl.kind          <= s1_ctl.kind;
    sum_ctl.last          <= s1_ctl.last;
    sum_ctl.rand_fraction <= s1_ctl.rand_fraction;
    sum_score             <= sum_comb;
  end

  // running best update
  assign lag_new = lags_seen + CNT_W'(1);
  assign better  = minimize ? (sum_score < best_so_far) : (sum_score > best_so_far);
  assign emit    = sum_ctl.valid && (sum_ctl.kind == KIND_CAND) && sum_ctl.last;

  always_comb begin
    upd_best  = best_so_far;
    upd_ties  = ties_held;
    upd_lags  = lags_seen;
    upd_ovf   = overflow_seen;
    tie_we    = 1'b0;
    tie_waddr = '0;
    if (lags_seen >= CNT_W'(MAX_LAGS)) begin
      upd_ovf = 1'b1;
    end else begin
      upd_lags = lag_new;
      if (ties_held == '0 || better) begin
        upd_best  = sum_score;
        upd_ties  = CNT_W'(1);
        tie_we    = sum_ctl.valid && (sum_ctl.kind == KIND_CAND);
        tie_waddr = '0;
      end else if (sum_score == best_so_far && ties_held < CNT_W'(MAX_LAGS)) begin
        upd_ties  = ties_held + CNT_W'(1);
        tie_we    = sum_ctl.valid && (sum_ctl.kind == KIND_CAND);
        tie_waddr = ties_held[IDX_W-1:0];
      end
    end
  end

  // center item or emitted result clears the search
  always_comb begin
    best_so_far_next   = best_so_far;
    ties_held_next     = ties_held;
    lags_seen_next     = lags_seen;
    overflow_seen_next = overflow_seen;
    if (sum_ctl.valid) begin
      if (sum_ctl.kind == KIND_CENTER || emit) begin
        best_so_far_next   = '0;
        ties_held_next     = '0;
        lags_seen_next     = '0;
        overflow_seen_next = 1'b0;
      end else begin
        best_so_far_next   = upd_best;
        ties_held_next     = upd_ties;
        lags_seen_next     = upd_lags;
        overflow_seen_next = upd_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_so_far   <= '0;
      ties_held     <= '0;
      lags_seen     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      best_so_far   <= best_so_far_next;
      ties_held     <= ties_held_next;
      lags_seen     <= lags_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tie_we) begin
      tie_mem[tie_waddr] <= lag_new;
    end
  end

  // snapshot of the finished search
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else begin
      pick_valid <= emit;
    end
    pick_best <= upd_best;
    pick_ties <= upd_ties;
    pick_ovf  <= upd_ovf;
    pick_rand <= sum_ctl.rand_fraction;
  end

  // tie position: floor(rand * count / 65536), always below count
  assign pick_prod = PROD_W'(pick_rand) * PROD_W'(pick_ties);
  assign pick_idx  = pick_prod[RAND_W +: IDX_W];

  // registered read; a write at the same edge belongs to the next search
  always_ff @(posedge clk) begin
    rd_lag <= tie_mem[pick_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= pick_valid;
    end
    rd_best <= pick_best;
    rd_ties <= pick_ties;
    rd_ovf  <= pick_ovf;
  end

  // result item
  assign res_item.best_lag   = LAG_OUT_W'(rd_lag);
  assign res_item.best_score = rd_best;
  assign res_item.tie_count  = LAG_OUT_W'(rd_ties);
  assign res_item.overflow   = rd_ovf;

endmodule

>>> rtl/lag_argbest_sqdiff_unit.sv
// lag_argbest_sqdiff_unit: top level; config register, center store, channel lanes,
// merge stage and result queue. Depends on lagbest_pkg, lagbest_lane, lagbest_merge.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  sample (sample_t)
//   result    out        result_valid / result_stall  result (result_t)
//   config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One item is taken every cycle while sample_stall is low. The edge that takes a last
// candidate registers its lane square; the result then passes the lane sum, best update,
// tie memory read and queue write registers before it is offered. The running best
// compare and update is done once per candidate, so the search never holds the input.
// Results wait in an eight-entry queue; sample_stall rises only when eight results
// are outstanding. Synchronous reset clears control, center and search state.

module lag_argbest_sqdiff_unit import lagbest_pkg::*; #(
  parameter int CHANNELS = DEFAULT_CHANNELS,
  parameter int MAX_LAGS = DEFAULT_MAX_LAGS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LANES   = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);

  logic                       minimize;
  logic                       sample_accept;
  logic signed [SAMPLE_W-1:0] center_value [FIELD_CH];
  logic signed [SAMPLE_W-1:0] sample_vals  [FIELD_CH];
  logic [SQ_W-1:0]            lane_sq      [LANES];
  stage_ctl_t                 s1_ctl;
  logic                       res_valid;
  result_t                    res_item;

  result_t                    fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]           wr_ptr, rd_ptr;
  logic [COUNT_W-1:0]         fifo_count, fifo_count_next;
  logic [COUNT_W-1:0]         pending, pending_next;
  logic                       pop;
  logic                       start_res;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimize <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_MINIMIZE) begin
      minimize <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MINIMIZE) begin
      prdata[0] = minimize;
    end
  end

  // input handshake
  assign sample_stall  = (pending == COUNT_W'(FIFO_DEPTH));
  assign sample_accept = sample_valid && !sample_stall;

  assign sample_vals[0] = sample.value_0;
  assign sample_vals[1] = sample.value_1;
  assign sample_vals[2] = sample.value_2;
  assign sample_vals[3] = sample.value_3;

  // center store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < FIELD_CH; c++) begin
        center_value[c] <= '0;
      end
    end else if (sample_accept && sample.kind == KIND_CENTER) begin
      for (int c = 0; c < FIELD_CH; c++) begin
        center_value[c] <= sample_vals[c];
      end
    end
  end

  // channel lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lagbest_lane u_lane (
      .clk    (clk),
      .center (center_value[l]),
      .sample (sample_vals[l]),
      .sq     (lane_sq[l])
    );
  end

  // control beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= sample_accept;
    end
    s1_ctl.kind          <= sample.kind;
    s1_ctl.last          <= sample.last;
    s1_ctl.rand_fraction <= sample.rand_fraction;
  end

  lagbest_merge #(
    .LANES    (LANES),
    .MAX_LAGS (MAX_LAGS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .minimize  (minimize),
    .s1_ctl    (s1_ctl),
    .lane_sq   (lane_sq),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // result queue and outstanding count
  assign start_res    = sample_accept && sample.kind == KIND_CAND && sample.last;
  assign pop          = result_valid && !result_stall;
  assign result_valid = (fifo_count != '0);
  assign result       = fifo_mem[rd_ptr];

  always_comb begin
    fifo_count_next = fifo_count;
    if (res_valid && !pop) begin
      fifo_count_next = fifo_count + COUNT_W'(1);
    end else if (!res_valid && pop) begin
      fifo_count_next = fifo_count - COUNT_W'(1);
    end
    pending_next = pending;
    if (start_res && !pop) begin
      pending_next = pending + COUNT_W'(1);
    end else if (!start_res && pop) begin
      pending_next = pending - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pending    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_count <= fifo_count_next;
      pending    <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res_item;
    end
  end

  // queued results never exceed those counted as outstanding
  assert property (@(posedge clk) disable iff (rst) fifo_count <= pending)
    else $error("result queue holds more items than outstanding");

  // a finished result always finds room in the queue
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_count < COUNT_W'(FIFO_DEPTH)) || pop)
    else $error("result arrived at a full queue");

  // a center item loads the center store
  assert property (@(posedge clk) disable iff (rst)
    (sample_accept && sample.kind == KIND_CENTER) |=> center_value[0] == $past(sample.value_0))
    else $error("center value not loaded");

endmodule

>>> sim/tb_lag_argbest_sqdiff_unit.sv
`timescale 1ns / 100ps
// tb_lag_argbest_sqdiff_unit: self-checking bench for the best-lag squared-difference search.
// Drives sample items from a queue, predicts each best-lag result, and checks the result items.
// Depends on lagbest_pkg and lag_argbest_sqdiff_unit.

module tb_lag_argbest_sqdiff_unit;
  import lagbest_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES  = 160;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  sample_t           sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // pending input items and expected best-lag results
  sample_t sample_queue[$];
  result_t expected_best[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // predictor state
  logic                       minimize_ref = 1'b0;
  logic signed [SAMPLE_W-1:0] center_ref [FIELD_CH];
  longint unsigned            best_ref = 0;
  logic [LAG_OUT_W-1:0]       tie_lags [DEFAULT_MAX_LAGS];
  int                         tie_total = 0;
  int                         lag_total = 0;
  logic                       lags_overflowed = 1'b0;

  // sender and receiver pacing
  bit          item_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          pattern_count = 0;

  lag_argbest_sqdiff_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // clear the running search, center kept
  function automatic void clear_search();
    best_ref = 0;
    tie_total = 0;
    lag_total = 0;
    lags_overflowed = 1'b0;
  endfunction

  // update the search with one accepted item, queue a result on the last candidate
  function automatic void predict_best(input sample_t s);
    logic signed [SAMPLE_W-1:0] cand [FIELD_CH];
    longint          diff;
    longint unsigned score;
    longint unsigned pick;
    result_t         best;
    cand[0] = s.value_0;
    cand[1] = s.value_1;
    cand[2] = s.value_2;
    cand[3] = s.value_3;
    if (s.kind == KIND_CENTER) begin
      for (int c = 0; c < FIELD_CH; c++) center_ref[c] = cand[c];
      clear_search();
      return;
    end
    if (lag_total >= DEFAULT_MAX_LAGS) begin
      lags_overflowed = 1'b1;
    end else begin
      score = 0;
      for (int c = 0; c < DEFAULT_CHANNELS && c < FIELD_CH; c++) begin
        diff = longint'(center_ref[c]) - longint'(cand[c]);
        score += longint'(diff * diff);
      end
      lag_total++;
      if (tie_total == 0 || (minimize_ref ? score < best_ref : score > best_ref)) begin
        best_ref = score;
        tie_lags[0] = LAG_OUT_W'(lag_total);
        tie_total = 1;
      end else if (score == best_ref && tie_total < DEFAULT_MAX_LAGS) begin
        tie_lags[tie_total] = LAG_OUT_W'(lag_total);
        tie_total++;
      end
    end
    if (!s.last) return;
    best = '0;
    best.overflow = lags_overflowed;
    if (tie_total != 0) begin
      pick = (longint'(s.rand_fraction) * tie_total) >> RAND_W;
      if (pick >= tie_total) pick = tie_total - 1;
      best.best_lag = tie_lags[pick];
      best.best_score = best_ref[SCORE_W-1:0];
      best.tie_count = LAG_OUT_W'(tie_total);
    end
    expected_best = {expected_best, best};
    clear_search();
  endfunction

  // compare one result item with the oldest expectation
  function automatic void check_best(input result_t got);
    result_t want;
    if (expected_best.size() == 0) begin
      $display("%0t: unexpected result lag=%0d score=%0d ties=%0d ovf=%0d", $time,
               got.best_lag, got.best_score, got.tie_count, got.overflow);
      mismatch_count++;
      return;
    end
    want = expected_best.pop_front();
    if (got.best_lag !== want.best_lag) begin
      $display("%0t: best_lag expected %0d actual %0d", $time, want.best_lag, got.best_lag);
      mismatch_count++;
    end
    if (got.best_score !== want.best_score) begin
      $display("%0t: best_score expected %0d actual %0d", $time,
               want.best_score, got.best_score);
      mismatch_count++;
    end
    if (got.tie_count !== want.tie_count) begin
      $display("%0t: tie_count expected %0d actual %0d", $time, want.tie_count, got.tie_count);
      mismatch_count++;
    end
    if (got.overflow !== want.overflow) begin
      $display("%0t: overflow expected %0d actual %0d", $time, want.overflow, got.overflow);
      mismatch_count++;
    end
  endfunction

  // sample acceptance feeds the predictor
  always @(posedge clk) begin
    item_taken = !rst && sample_valid && !sample_stall;
    if (item_taken) predict_best(sample);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_best(result);
  end

  // sample driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        sample_valid <= 1'b0;
      end else begin
        sample <= sample_queue.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // result stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    pattern_count++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:     result_stall <= 1'b0;
        STALL_SPARSE:   result_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: result_stall <= (pattern_count % 3 == 0);
        default:        result_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // one config transfer: setup then access
  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_MINIMIZE;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the minimize register and read it back
  task automatic set_minimize(input logic value, input logic [DATA_W-1:0] upper);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] readback;
    word = upper;
    word[0] = value;
    apb_access(1'b1, word, readback);
    minimize_ref = value;
    apb_access(1'b0, '0, readback);
    if (readback[0] !== value) begin
      $display("%0t: minimize readback expected %0d actual %0d", $time, value, readback[0]);
      mismatch_count++;
    end
  endtask

  // wait until every item is taken and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (sample_queue.size() != 0 || sample_valid || expected_best.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_item(input logic kind, input logic [15:0] v0,
                                    input logic [15:0] v1, input logic [15:0] v2,
                                    input logic [15:0] v3, input logic last,
                                    input logic [15:0] frac);
    sample_t s;
    s.kind = kind;
    s.value_0 = v0;
    s.value_1 = v1;
    s.value_2 = v2;
    s.value_3 = v3;
    s.last = last;
    s.rand_fraction = frac;
    sample_queue = {sample_queue, s};
  endfunction

  // channel value biased toward the extremes
  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // random points: center, candidates, last; some noise and broken points
  task automatic queue_random_points(input int target, input int short_first);
    int          issued;
    int          count;
    int          style;
    int          sel;
    logic        drop_last;
    logic [15:0] palette [3][FIELD_CH];
    logic [15:0] v [FIELD_CH];
    issued = 0;
    // short points so results pile up quickly
    for (int i = 0; i < short_first; i++) begin
      push_item(KIND_CENTER, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                1'b0, 16'($urandom));
      push_item(KIND_CAND, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                1'b1, 16'($urandom));
      issued += 2;
    end
    while (issued < target) begin
      if ($urandom_range(0, 99) < 8) begin
        // stray item of any kind
        push_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), 16'($urandom));
        issued++;
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          if ($urandom_range(0, 1) == 0)
            push_item(KIND_CENTER, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), ($urandom_range(0, 9) == 0), 16'($urandom));
          else
            push_item(KIND_CENTER, edge_value(), edge_value(), edge_value(), edge_value(),
                      ($urandom_range(0, 9) == 0), 16'($urandom));
          issued++;
        end
        sel = $urandom_range(0, 99);
        if (sel < 4)       count = $urandom_range(60, 70);
        else if (sel < 19) count = $urandom_range(9, 30);
        else               count = $urandom_range(1, 8);
        style = $urandom_range(0, 2);
        drop_last = ($urandom_range(0, 99) < 8);
        for (int p = 0; p < 3; p++)
          for (int c = 0; c < FIELD_CH; c++) palette[p][c] = edge_value();
        for (int k = 0; k < count; k++) begin
          sel = $urandom_range(0, 2);
          for (int c = 0; c < FIELD_CH; c++) begin
            case (style)
              0:       v[c] = 16'($urandom);
              1:       v[c] = palette[sel][c];
              default: v[c] = edge_value();
            endcase
          end
          push_item(KIND_CAND, v[0], v[1], v[2], v[3], (k == count - 1) && !drop_last,
                    16'($urandom));
          issued++;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    for (int c = 0; c < FIELD_CH; c++) center_ref[c] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_minimize(1'b0, '0);

    // largest score: zero center after reset, center with last, max-score ties,
    // extreme tie-break fractions, candidate after a result reusing the center
    push_item(KIND_CAND, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'h0000);
    push_item(KIND_CENTER, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'hFFFF);
    push_item(KIND_CAND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h1234);
    push_item(KIND_CAND, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'hFFFF);
    push_item(KIND_CAND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF);
    push_item(KIND_CENTER, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1, 16'h8000);
    push_item(KIND_CAND, 16'h0000, 16'h0000, 16'h0002, 16'h0000, 1'b1, 16'h0000);
    wait_drained();

    // smallest score: zero-score ties, center with last, lone candidate
    set_minimize(1'b1, '1);
    push_item(KIND_CENTER, 16'h04D2, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h04D2, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h04D3, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b0, 16'hFFFF);
    push_item(KIND_CAND, 16'h04D2, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 16'h0000);
    push_item(KIND_CAND, 16'h04D2, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b1, 16'hFFFF);
    push_item(KIND_CENTER, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 1'b1, 16'hFFFF);
    push_item(KIND_CAND, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h5555);
    queue_random_points(250, 0);
    wait_drained();

    // largest score, receiver held off while the sender keeps going
    set_minimize(1'b0, DATA_W'($urandom));
    @(posedge clk);
    hold_req = 1'b1;
    queue_random_points(250, 30);
    wait_drained();

    set_minimize(1'b1, DATA_W'($urandom));
    queue_random_points(250, 0);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
